@@ sv/srg_pkg.sv @@
package srg_pkg;

  // Register indexes of the configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_MIN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_MAX  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROI_START  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROI_END    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCAN_START = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_STEP = 3'd5;

  // Rotator constants. Angles are 32-bit turn fractions, vectors are Q30.
  localparam int CORDIC_ITERS = 24;
  localparam int TURN_W       = 32;
  localparam int VEC_W        = 32;
  localparam int Q30_SHIFT    = 30;

  typedef logic signed [VEC_W-1:0] vec_t;

  localparam vec_t       CORDIC_K    = 32'sd652032874;
  localparam vec_t       Q30_ONE     = 32'sd1073741824;
  localparam vec_t       Q30_NEG_ONE = -32'sd1073741824;
  localparam logic [TURN_W-1:0] EIGHTH_TURN = 32'd536870912;
  localparam vec_t       EIGHTH_TURN_S = 32'sd536870912;

  // Arctangent of 2^-i in units of 2^32 per turn.
  localparam vec_t ATAN_TURN32 [0:CORDIC_ITERS-1] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

endpackage

@@ sv/scan_range_gate_to_points.sv @@
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------
// in_       | in_tvalid/in_tready  | tdata: range_mm; tuser: range_invalid,
//           |                      | first_of_scan; tlast: last_of_scan
// out_      | out_tvalid/out_tready| tdata: point_x_mm, point_y_mm; tuser: keep;
//           |                      | tlast: scan_done
// cfg_      | cfg_we               | cfg_addr selects the register, cfg_wdata
//
// The block takes one word per cycle while the output is not stalled and returns one
// word per input word, in order. Each word passes through the gate and angle-fold
// register, a register per rotator iteration, the clamp and quadrant-swap register,
// the register for the two multiplies and the rounding output register, in that order.
// A stall on the output freezes the whole pipeline, so in_tready follows out_tready
// whenever the output register holds a word.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the beam angle and loads
// the default register values. A register write affects the next word accepted.
module scan_range_gate_to_points #(
  parameter int ANGLE_BITS = 16,
  parameter int RANGE_BITS = 16,
  localparam int CfgW     = (RANGE_BITS > ANGLE_BITS + 1) ? RANGE_BITS : ANGLE_BITS + 1,
  localparam int InDataW  = ((RANGE_BITS + 7) / 8) * 8,
  localparam int OutDataW = ((2 * (RANGE_BITS + 1) + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [InDataW-1:0]            in_tdata,   // [RANGE_BITS-1:0] range_mm
  input  logic [1:0]                    in_tuser,   // [0] range_invalid, [1] first_of_scan
  input  logic                          in_tlast,   // last_of_scan
  // Result stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OutDataW-1:0]           out_tdata,  // point_x_mm, then point_y_mm, signed
  output logic [0:0]                    out_tuser,  // [0] keep
  output logic                          out_tlast,  // scan_done
  // Configuration writes.
  input  logic                          cfg_we,
  input  logic [srg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CfgW-1:0]               cfg_wdata
);
  import srg_pkg::*;

  localparam int PtW   = RANGE_BITS + 1;
  localparam int ProdW = RANGE_BITS + VEC_W + 1;
  localparam int NIt   = CORDIC_ITERS;

  // Configuration registers.
  logic [RANGE_BITS-1:0]  range_min_r, range_max_r;
  logic [ANGLE_BITS:0]    roi_start_r, roi_end_r;
  logic [ANGLE_BITS-1:0]  scan_start_r, angle_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r  <= RANGE_BITS'(100);
      range_max_r  <= RANGE_BITS'(16000);
      roi_start_r  <= '0;
      roi_end_r    <= {1'b1, {ANGLE_BITS{1'b0}}};
      scan_start_r <= '0;
      angle_step_r <= ANGLE_BITS'(182);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RANGE_MIN:  range_min_r  <= cfg_wdata[RANGE_BITS-1:0];
        CFG_RANGE_MAX:  range_max_r  <= cfg_wdata[RANGE_BITS-1:0];
        CFG_ROI_START:  roi_start_r  <= cfg_wdata[ANGLE_BITS:0];
        CFG_ROI_END:    roi_end_r    <= cfg_wdata[ANGLE_BITS:0];
        CFG_SCAN_START: scan_start_r <= cfg_wdata[ANGLE_BITS-1:0];
        CFG_ANGLE_STEP: angle_step_r <= cfg_wdata[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is empty or being drained.
  logic adv;
  logic in_acc;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  // Input decode, beam angle and gates.
  logic [RANGE_BITS-1:0] in_range;
  logic                  in_invalid, in_first;
  logic [ANGLE_BITS-1:0] ang, beam_angle_r, beam_angle_nxt;
  logic [ANGLE_BITS:0]   ang_x;
  logic                  range_ok, roi_ok;
  logic [TURN_W-1:0]     turn, turn_rot;

  assign in_range   = in_tdata[RANGE_BITS-1:0];
  assign in_invalid = in_tuser[0];
  assign in_first   = in_tuser[1];

  assign ang            = in_first ? scan_start_r : beam_angle_r;
  assign ang_x          = {1'b0, ang};
  assign beam_angle_nxt = ang + angle_step_r;

  assign range_ok = !in_invalid && (in_range >= range_min_r) && (in_range <= range_max_r);

  // A window whose start is at or above its end wraps through zero.
  always_comb begin
    if (roi_start_r >= roi_end_r) begin
      roi_ok = (ang_x >= roi_start_r) || (ang_x <= roi_end_r);
    end else begin
      roi_ok = (ang_x >= roi_start_r) && (ang_x <= roi_end_r);
    end
  end

  // Shift the angle up by one eighth turn so the quadrant index sits in the top two bits
  // and the residual lands in [-1/8, 1/8) of a turn.
  assign turn     = {ang, {(TURN_W - ANGLE_BITS){1'b0}}};
  assign turn_rot = turn + EIGHTH_TURN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_angle_r <= '0;
    end else if (in_acc) begin
      beam_angle_r <= beam_angle_nxt;
    end
  end

  // Stage A: gated sample, quadrant and residual angle.
  logic                  a_valid_r, a_keep_r, a_last_r;
  logic [RANGE_BITS-1:0] a_range_r;
  logic [1:0]            a_quad_r;
  vec_t                  a_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_keep_r  <= range_ok && roi_ok;
      a_last_r  <= in_tlast;
      a_range_r <= in_range;
      a_quad_r  <= turn_rot[TURN_W-1 -: 2];
      a_z_r     <= $signed({2'b00, turn_rot[TURN_W-3:0]}) - EIGHTH_TURN_S;
    end
  end

  // Rotator: one iteration per stage. Index 0 of the wire arrays is the stage A output.
  logic                  vw [0:NIt];
  logic                  kw [0:NIt];
  logic                  lw [0:NIt];
  logic [RANGE_BITS-1:0] rw [0:NIt];
  logic [1:0]            qw [0:NIt];
  vec_t                  xw [0:NIt];
  vec_t                  yw [0:NIt];
  vec_t                  zw [0:NIt];

  assign vw[0] = a_valid_r;
  assign kw[0] = a_keep_r;
  assign lw[0] = a_last_r;
  assign rw[0] = a_range_r;
  assign qw[0] = a_quad_r;
  assign xw[0] = CORDIC_K;
  assign yw[0] = '0;
  assign zw[0] = a_z_r;

  for (genvar gi = 0; gi < NIt; gi++) begin : g_rot
    logic                  valid_r, keep_r, last_r;
    logic [RANGE_BITS-1:0] range_r;
    logic [1:0]            quad_r;
    vec_t                  x_r, y_r, z_r;
    vec_t                  dx, dy;

    // Arithmetic right shifts floor, as the rotator requires.
    assign dx = yw[gi] >>> gi;
    assign dy = xw[gi] >>> gi;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (adv) begin
        valid_r <= vw[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        keep_r  <= kw[gi];
        last_r  <= lw[gi];
        range_r <= rw[gi];
        quad_r  <= qw[gi];
        if (!zw[gi][VEC_W-1]) begin
          x_r <= xw[gi] - dx;
          y_r <= yw[gi] + dy;
          z_r <= zw[gi] - ATAN_TURN32[gi];
        end else begin
          x_r <= xw[gi] + dx;
          y_r <= yw[gi] - dy;
          z_r <= zw[gi] + ATAN_TURN32[gi];
        end
      end
    end

    assign vw[gi+1] = valid_r;
    assign kw[gi+1] = keep_r;
    assign lw[gi+1] = last_r;
    assign rw[gi+1] = range_r;
    assign qw[gi+1] = quad_r;
    assign xw[gi+1] = x_r;
    assign yw[gi+1] = y_r;
    assign zw[gi+1] = z_r;
  end

  // Stage B: clamp to [-1, 1] and rotate back by whole quadrants.
  vec_t x_cl, y_cl, cos_nxt, sin_nxt;

  assign x_cl = (xw[NIt] > Q30_ONE) ? Q30_ONE :
                (xw[NIt] < Q30_NEG_ONE) ? Q30_NEG_ONE : xw[NIt];
  assign y_cl = (yw[NIt] > Q30_ONE) ? Q30_ONE :
                (yw[NIt] < Q30_NEG_ONE) ? Q30_NEG_ONE : yw[NIt];

  always_comb begin
    case (qw[NIt])
      2'd0: begin
        cos_nxt = x_cl;
        sin_nxt = y_cl;
      end
      2'd1: begin
        cos_nxt = -y_cl;
        sin_nxt = x_cl;
      end
      2'd2: begin
        cos_nxt = -x_cl;
        sin_nxt = -y_cl;
      end
      default: begin
        cos_nxt = y_cl;
        sin_nxt = -x_cl;
      end
    endcase
  end

  logic                  b_valid_r, b_keep_r, b_last_r;
  logic [RANGE_BITS-1:0] b_range_r;
  vec_t                  b_cos_r, b_sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= vw[NIt];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_keep_r  <= kw[NIt];
      b_last_r  <= lw[NIt];
      b_range_r <= rw[NIt];
      b_cos_r   <= cos_nxt;
      b_sin_r   <= sin_nxt;
    end
  end

  // Stage C: range times cosine and sine.
  logic signed [ProdW-1:0] range_s, cos_s, sin_s;
  logic                    c_valid_r, c_keep_r, c_last_r;
  logic signed [ProdW-1:0] c_px_r, c_py_r;

  assign range_s = ProdW'($signed({1'b0, b_range_r}));
  assign cos_s   = ProdW'(b_cos_r);
  assign sin_s   = ProdW'(b_sin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_keep_r <= b_keep_r;
      c_last_r <= b_last_r;
      c_px_r   <= range_s * cos_s;
      c_py_r   <= range_s * sin_s;
    end
  end

  // Output: round half up to whole millimetres. With cosine and sine held within
  // [-1, 1] the rounded product already fits in the signed output without saturation.
  logic signed [ProdW-1:0] px_rnd, py_rnd;
  logic signed [PtW-1:0]   px_nxt, py_nxt;

  assign px_rnd = (c_px_r + ProdW'(Q30_ONE >>> 1)) >>> Q30_SHIFT;
  assign py_rnd = (c_py_r + ProdW'(Q30_ONE >>> 1)) >>> Q30_SHIFT;
  assign px_nxt = c_keep_r ? px_rnd[PtW-1:0] : '0;
  assign py_nxt = c_keep_r ? py_rnd[PtW-1:0] : '0;

  logic                  out_valid_r, out_keep_r, out_last_r;
  logic signed [PtW-1:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_keep_r <= c_keep_r;
      out_last_r <= c_last_r;
      out_x_r    <= px_nxt;
      out_y_r    <= py_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OutDataW'({out_y_r, out_x_r});
  assign out_tuser[0] = out_keep_r;
  assign out_tlast    = out_last_r;

  // A rejected sample always leaves with a zero point.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_keep_r |-> (out_x_r == '0) && (out_y_r == '0))
    else $error("rejected sample carries a nonzero point");

  // A held output word stops the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted while the output is stalled");

  // The first sample of a scan restarts the beam angle from the start register.
  a_first_reload: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_first |=>
      beam_angle_r == ANGLE_BITS'($past(scan_start_r) + $past(angle_step_r)))
    else $error("beam angle not reloaded on first sample");

  // Words that are not accepted leave the beam angle alone.
  a_angle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(beam_angle_r))
    else $error("beam angle moved without an accepted word");

endmodule
